/* design/smc_pkg.sv */
// Shared constants for the seam matching cost block.
package smc_pkg;

    localparam int FIELD_W      = 8;
    localparam int NUM_FIELDS   = 12;
    localparam int NUM_CHANNELS = 3;
    localparam int DIVISOR_W    = 8;
    localparam int RESULT_W     = 9;
    localparam int CFG_INDEX_W  = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_COST_MODE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_REDUCTION = 2'd1;

    localparam logic MODE_BASIC    = 1'b0;
    localparam logic MODE_GRADIENT = 1'b1;

endpackage

/* design/seam_matching_cost.sv */
// Seam matching cost: pipelined edge cost between two adjacent pixels.
//
// The slave stream carries one edge per transaction: old and new RGB colours
// at pixels s and t. The master stream returns one edge cost per transaction.
// Configuration arrives on its own write channel (cfg_valid, cfg_ready,
// cfg_index, cfg_data) and is always ready; the user must write it only while
// the block is idle, as the block itself does not enforce this.
// Throughput is one transaction per cycle unless the receiver stalls. The
// stages are one stage of absolute differences, one of division by three,
// one squaring stage, one stage per quotient bit of the shared divide and
// square-root bit loop, and the output register.
// Every stage has its own valid bit and moves when the next stage is empty or
// moving, so a receiver stall fills empty stages first and s_tready falls only
// once the whole pipeline is full. Nothing is lost or repeated on a stall.
// A synchronous reset empties the pipeline and sets basic mode with a
// reduction divisor of one.
module seam_matching_cost
    import smc_pkg::*;
#(
    parameter int CHANNEL_BITS = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // old_s_red, old_s_green, old_s_blue, new_s_red, new_s_green, new_s_blue,
    // old_t_red, old_t_green, old_t_blue, new_t_red, new_t_green, new_t_blue
    input  logic [95:0]            s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // edge_cost [8:0], zeros above
    output logic [15:0]            m_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [DIVISOR_W-1:0]   cfg_data
);

    localparam int EFF_W  = (CHANNEL_BITS < FIELD_W) ? CHANNEL_BITS : FIELD_W;
    localparam int COST_W = EFF_W + 1;
    localparam int SUM_W  = EFF_W + 3;
    localparam int RK     = ((EFF_W + 3) % 2 == 1) ? (EFF_W + 3) : (EFF_W + 4);
    localparam int RECIP  = ((1 << RK) + 1) / 3;
    localparam int PROD_W = SUM_W + RK;
    localparam int SQ_W   = 2 * COST_W;
    localparam int CAND_W = 3 * COST_W;

    typedef struct packed {
        logic                 mode;
        logic [DIVISOR_W-1:0] d;
        logic [SUM_W-1:0]     diff_sum;
        logic [SUM_W-1:0]     tex_grad;
        logic [SUM_W-1:0]     pat_grad;
    } sum_t;

    typedef struct packed {
        logic                 mode;
        logic [DIVISOR_W-1:0] d;
        logic [COST_W-1:0]    c;
        logic [COST_W-1:0]    g;
    } norm_t;

    typedef struct packed {
        logic                 mode;
        logic [DIVISOR_W-1:0] d;
        logic [COST_W-1:0]    c;
        logic [COST_W-1:0]    g;
        logic [DIVISOR_W-1:0] rem;
        logic [COST_W-1:0]    quo;
        logic [SQ_W-1:0]      lim;
        logic [SQ_W-1:0]      p;
        logic [SQ_W-1:0]      r;
        logic [COST_W-1:0]    q;
    } iter_t;

    logic                 cost_mode_reg;
    logic [DIVISOR_W-1:0] reduction_divisor_reg;

    logic  v1_reg, v2_reg, out_v_reg;
    sum_t  s1_reg, s1_next;
    norm_t s2_reg, s2_next;
    iter_t it_reg  [COST_W+1];
    iter_t it_next [COST_W+1];
    logic  it_v_reg [COST_W+1];
    logic  adv_it   [COST_W+1];
    logic  adv1, adv2, adv_out;
    logic [COST_W-1:0] out_reg, out_next;

    logic [EFF_W-1:0] chan [NUM_FIELDS];

    function automatic logic [EFF_W-1:0] absdiff(input logic [EFF_W-1:0] a,
                                                 input logic [EFF_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cost_mode_reg         <= MODE_BASIC;
            reduction_divisor_reg <= DIVISOR_W'(1);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_COST_MODE: cost_mode_reg         <= cfg_data[0];
                REG_REDUCTION: reduction_divisor_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Backward flow control: a stage moves when it is empty or its successor moves.
    assign adv_out = !out_v_reg || m_tready;
    assign adv_it[COST_W] = !it_v_reg[COST_W] || adv_out;
    for (genvar k = 0; k < COST_W; k++) begin : g_adv
        assign adv_it[k] = !it_v_reg[k] || adv_it[k+1];
    end
    assign adv2     = !v2_reg || adv_it[0];
    assign adv1     = !v1_reg || adv2;
    assign s_tready = adv1;

    for (genvar f = 0; f < NUM_FIELDS; f++) begin : g_chan
        assign chan[f] = s_tdata[f*FIELD_W +: EFF_W];
    end

    always_comb begin
        s1_next          = '0;
        s1_next.mode     = cost_mode_reg;
        s1_next.d        = (reduction_divisor_reg == '0) ? DIVISOR_W'(1)
                                                         : reduction_divisor_reg;
        for (int k = 0; k < NUM_CHANNELS; k++) begin
            s1_next.diff_sum = s1_next.diff_sum
                             + SUM_W'(absdiff(chan[k], chan[3+k]))
                             + SUM_W'(absdiff(chan[6+k], chan[9+k]));
            s1_next.tex_grad = s1_next.tex_grad + SUM_W'(absdiff(chan[k], chan[6+k]));
            s1_next.pat_grad = s1_next.pat_grad + SUM_W'(absdiff(chan[3+k], chan[9+k]));
        end
    end

    // Division by three through a reciprocal that is exact over the sum range.
    logic [PROD_W-1:0] c_prod, tg_prod, pg_prod;
    always_comb begin
        c_prod    = PROD_W'(s1_reg.diff_sum) * PROD_W'(RECIP);
        tg_prod   = PROD_W'(s1_reg.tex_grad) * PROD_W'(RECIP);
        pg_prod   = PROD_W'(s1_reg.pat_grad) * PROD_W'(RECIP);
        s2_next.mode = s1_reg.mode;
        s2_next.d    = s1_reg.d;
        s2_next.c    = COST_W'(c_prod >> RK);
        s2_next.g    = COST_W'(1) + COST_W'(tg_prod >> RK) + COST_W'(pg_prod >> RK);
    end

    always_comb begin
        it_next[0]      = '0;
        it_next[0].mode = s2_reg.mode;
        it_next[0].d    = s2_reg.d;
        it_next[0].c    = s2_reg.c;
        it_next[0].g    = s2_reg.g;
        it_next[0].lim  = SQ_W'(s2_reg.c) * SQ_W'(s2_reg.c);
    end

    // One quotient bit per stage: restoring division and the exact root search
    // share the stage, with q*q*g and q*g kept so that each step only adds.
    for (genvar k = 1; k <= COST_W; k++) begin : g_iter
        localparam int B = COST_W - k;
        logic [DIVISOR_W:0] rem_sh;
        logic [CAND_W-1:0]  cand;
        always_comb begin
            it_next[k] = it_reg[k-1];
            rem_sh = {it_reg[k-1].rem, it_reg[k-1].c[B]};
            if (rem_sh >= {1'b0, it_reg[k-1].d}) begin
                it_next[k].rem    = DIVISOR_W'(rem_sh - {1'b0, it_reg[k-1].d});
                it_next[k].quo[B] = 1'b1;
            end else begin
                it_next[k].rem = DIVISOR_W'(rem_sh);
            end
            cand = CAND_W'(it_reg[k-1].p)
                 + (CAND_W'(it_reg[k-1].r) << (B + 1))
                 + (CAND_W'(it_reg[k-1].g) << (2 * B));
            if (cand <= CAND_W'(it_reg[k-1].lim)) begin
                it_next[k].p    = SQ_W'(cand);
                it_next[k].r    = it_reg[k-1].r + (SQ_W'(it_reg[k-1].g) << B);
                it_next[k].q[B] = 1'b1;
            end
        end
    end

    assign out_next = (it_reg[COST_W].mode == MODE_GRADIENT) ? it_reg[COST_W].q
                                                             : it_reg[COST_W].quo;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            out_v_reg <= 1'b0;
        end else begin
            if (adv1)    v1_reg    <= s_tvalid;
            if (adv2)    v2_reg    <= v1_reg;
            if (adv_out) out_v_reg <= it_v_reg[COST_W];
        end
        if (adv1)    s1_reg  <= s1_next;
        if (adv2)    s2_reg  <= s2_next;
        if (adv_out) out_reg <= out_next;
    end

    for (genvar k = 0; k <= COST_W; k++) begin : g_it_reg
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                it_v_reg[k] <= 1'b0;
            end else if (adv_it[k]) begin
                if (k == 0) begin
                    it_v_reg[k] <= v2_reg;
                end else begin
                    it_v_reg[k] <= it_v_reg[(k == 0) ? 0 : k-1];
                end
            end
            if (adv_it[k]) begin
                it_reg[k] <= it_next[k];
            end
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = 16'(RESULT_W'(out_reg));

    a_full_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready && it_v_reg[COST_W] && v1_reg))
        else $error("input blocked while the pipeline has room");

    a_root_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (it_v_reg[COST_W] && it_reg[COST_W].mode == MODE_GRADIENT) |->
        (it_reg[COST_W].p <= it_reg[COST_W].lim &&
         CAND_W'(it_reg[COST_W].p) == CAND_W'(it_reg[COST_W].q) *
             CAND_W'(it_reg[COST_W].q) * CAND_W'(it_reg[COST_W].g)))
        else $error("root search lost its running square product");

    a_div_exact: assert property (@(posedge aclk) disable iff (!aresetn)
        (it_v_reg[COST_W] && it_reg[COST_W].mode == MODE_BASIC) |->
        (it_reg[COST_W].rem < it_reg[COST_W].d &&
         SQ_W'(it_reg[COST_W].quo) * SQ_W'(it_reg[COST_W].d) +
             SQ_W'(it_reg[COST_W].rem) == SQ_W'(it_reg[COST_W].c)))
        else $error("divider quotient and remainder disagree with the cost");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && !v1_reg && !v2_reg))
        else $error("pipeline not empty after reset");

endmodule
